// ===== rtl/rprop_weight_update_macros.svh =====
// assertion helpers for the rprop weight update block
// both sample on the rising edge of clk and are off while rst_n is low
`ifndef RPROP_WEIGHT_UPDATE_MACROS_SVH
`define RPROP_WEIGHT_UPDATE_MACROS_SVH

// consequent checked in the same cycle as the antecedent
`define RPROP_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// consequent checked in the cycle after the antecedent
`define RPROP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/rprop_pkg.sv =====
package rprop_pkg;

    localparam int INDEX_W  = 12;
    localparam int GRAD_W   = 32;
    localparam int WEIGHT_W = 32;
    localparam int STEP_W   = 31;
    localparam int BRANCH_W = 2;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    // table reset contents
    localparam logic signed [GRAD_W-1:0]   RESET_GRADIENT = 32'sd65536;
    localparam logic [STEP_W-1:0]          RESET_STEP     = 31'd6554;
    localparam logic signed [WEIGHT_W-1:0] RESET_CHANGE   = 32'sd6554;

    // register reset values
    localparam logic [STEP_W-1:0] RESET_STEP_FLOOR   = 31'd1;
    localparam logic [STEP_W-1:0] RESET_STEP_CEILING = 31'd3276800;

    // floor(x / 5) = (x * DIV5_MULT) >> DIV5_SHIFT, exact for x < 2^31
    localparam logic [31:0] DIV5_MULT  = 32'd1717986919;
    localparam int          DIV5_SHIFT = 33;

    // register select (paddr bit 2)
    typedef logic reg_sel_t;
    localparam reg_sel_t REG_STEP_FLOOR   = 1'b0;
    localparam reg_sel_t REG_STEP_CEILING = 1'b1;

    typedef logic [BRANCH_W-1:0] branch_t;
    localparam branch_t BR_GROW = 2'd0;
    localparam branch_t BR_FLIP = 2'd1;
    localparam branch_t BR_KEEP = 2'd2;

    typedef struct packed {
        logic signed [GRAD_W-1:0]   grad;
        logic [STEP_W-1:0]          step;
        logic signed [WEIGHT_W-1:0] change;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    localparam entry_t ENTRY_RESET = '{
        grad:   RESET_GRADIENT,
        step:   RESET_STEP,
        change: RESET_CHANGE
    };

    typedef struct packed {
        logic signed [WEIGHT_W-1:0] weight_next;
        logic [STEP_W-1:0]          step_now;
        branch_t                    branch_taken;
        logic                       saturated;
    } result_t;

endpackage

// ===== rtl/rprop_in_if.sv =====
interface rprop_in_if;
    logic                                     valid;
    logic                                     ready;
    logic [rprop_pkg::INDEX_W-1:0]            weight_index;
    logic signed [rprop_pkg::GRAD_W-1:0]      gradient;
    logic signed [rprop_pkg::WEIGHT_W-1:0]    weight_now;

    modport source (
        output valid,
        output weight_index,
        output gradient,
        output weight_now,
        input  ready
    );

    modport sink (
        input  valid,
        input  weight_index,
        input  gradient,
        input  weight_now,
        output ready
    );
endinterface

// ===== rtl/rprop_out_if.sv =====
interface rprop_out_if;
    logic                                     valid;
    logic                                     ready;
    logic signed [rprop_pkg::WEIGHT_W-1:0]    weight_next;
    logic [rprop_pkg::STEP_W-1:0]             step_now;
    logic [rprop_pkg::BRANCH_W-1:0]           branch_taken;
    logic                                     saturated;

    modport source (
        output valid,
        output weight_next,
        output step_now,
        output branch_taken,
        output saturated,
        input  ready
    );

    modport sink (
        input  valid,
        input  weight_next,
        input  step_now,
        input  branch_taken,
        input  saturated,
        output ready
    );
endinterface

// ===== rtl/rprop_ram.sv =====
module rprop_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/rprop_idx.sv =====
// weight_index modulo NUM_WEIGHTS, one register stage
module rprop_idx #(
    parameter int NUM_WEIGHTS = 4096,
    localparam int IDX_W = (NUM_WEIGHTS > 1) ? $clog2(NUM_WEIGHTS) : 1
) (
    input  logic                          clk,
    input  logic                          en,
    input  logic [rprop_pkg::INDEX_W-1:0] weight_index,
    output logic [IDX_W-1:0]              idx
);

    localparam int  XW     = rprop_pkg::INDEX_W;
    localparam bit  FULL   = (NUM_WEIGHTS >= (1 << XW));
    localparam bit  POW2   = (NUM_WEIGHTS > 1) && ((NUM_WEIGHTS & (NUM_WEIGHTS - 1)) == 0);
    localparam int  RSHIFT = 2 * XW;
    localparam int  RW     = RSHIFT + 1;
    localparam int  PW     = RW + XW;

    logic [XW-1:0] x_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg <= weight_index;
        end
    end

    if (FULL)
    begin : g_full
        assign idx = IDX_W'(x_reg);
    end
    else if (POW2)
    begin : g_pow2
        assign idx = x_reg[IDX_W-1:0];
    end
    else
    begin : g_recip
        // quotient by reciprocal, exact for every 12-bit index
        localparam longint RECIP = ((64'd1 << RSHIFT) + NUM_WEIGHTS - 1) / NUM_WEIGHTS;
        localparam logic [RW-1:0] RECIP_C = RW'(RECIP);
        localparam logic [XW-1:0] NUM_C   = XW'(NUM_WEIGHTS);

        logic [PW-1:0]   quot_prod;
        logic [XW-1:0]   q_reg;
        logic [2*XW-1:0] qn;
        logic [XW-1:0]   diff;

        assign quot_prod = PW'(weight_index) * PW'(RECIP_C);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                q_reg <= quot_prod[RSHIFT +: XW];
            end
        end

        assign qn   = (2*XW)'(q_reg) * (2*XW)'(NUM_C);
        assign diff = x_reg - qn[XW-1:0];
        assign idx  = diff[IDX_W-1:0];
    end

endmodule

// ===== rtl/rprop_calc.sv =====
// rprop step and weight update for one table entry
module rprop_calc (
    input  logic signed [rprop_pkg::GRAD_W-1:0]   gradient,
    input  logic signed [rprop_pkg::WEIGHT_W-1:0] weight_now,
    input  rprop_pkg::entry_t                     prev,
    input  logic [rprop_pkg::STEP_W-1:0]          step_floor,
    input  logic [rprop_pkg::STEP_W-1:0]          step_ceiling,
    output rprop_pkg::result_t                    res,
    output rprop_pkg::entry_t                     upd
);

    localparam int SW = rprop_pkg::STEP_W;
    localparam int WW = rprop_pkg::WEIGHT_W;
    localparam logic signed [WW-1:0] W_MAX = {1'b0, {(WW-1){1'b1}}};
    localparam logic signed [WW-1:0] W_MIN = {1'b1, {(WW-1){1'b0}}};

    logic g_pos, g_neg, p_pos, p_neg;
    logic flip, grow;
    logic [2*SW:0]     fifth_prod;
    logic [SW-1:0]     fifth;
    logic [SW:0]       grown;
    logic [SW-1:0]     grow_step;
    logic [SW-1:0]     halved;
    logic [SW-1:0]     shrink_step;
    logic [SW-1:0]     step_sel;
    logic signed [WW:0] addend;
    logic signed [WW:0] sum;
    logic signed [WW-1:0] flip_change;
    logic sat;

    assign fifth_prod = (2*SW+1)'(prev.step) * (2*SW+1)'(rprop_pkg::DIV5_MULT);
    assign fifth      = SW'(fifth_prod >> rprop_pkg::DIV5_SHIFT);

    always_comb
    begin
        g_pos = !gradient[WW-1] && (gradient != '0);
        g_neg = gradient[WW-1];
        p_pos = !prev.grad[WW-1] && (prev.grad != '0);
        p_neg = prev.grad[WW-1];
        flip  = (g_pos && p_neg) || (g_neg && p_pos);
        grow  = (g_pos && p_pos) || (g_neg && p_neg);

        // growth by 6/5 = s + s/5, capped
        grown = {1'b0, prev.step} + {1'b0, fifth};
        if (grown > {1'b0, step_ceiling})
        begin
            grow_step = step_ceiling;
        end
        else
        begin
            grow_step = grown[SW-1:0];
        end

        // halving, floored
        halved = {1'b0, prev.step[SW-1:1]};
        if (halved < step_floor)
        begin
            shrink_step = step_floor;
        end
        else
        begin
            shrink_step = halved;
        end

        // negating the most negative change saturates
        if (prev.change == W_MIN)
        begin
            flip_change = W_MAX;
        end
        else
        begin
            flip_change = -prev.change;
        end

        if (flip)
        begin
            step_sel = shrink_step;
        end
        else if (grow)
        begin
            step_sel = grow_step;
        end
        else
        begin
            step_sel = prev.step;
        end

        if (flip)
        begin
            addend = -$signed({prev.change[WW-1], prev.change});
        end
        else if (g_pos)
        begin
            addend = -$signed({2'b00, step_sel});
        end
        else if (g_neg)
        begin
            addend = $signed({2'b00, step_sel});
        end
        else
        begin
            addend = '0;
        end

        sum = $signed({weight_now[WW-1], weight_now}) + addend;
        sat = (sum[WW] != sum[WW-1]);

        res.step_now  = step_sel;
        res.saturated = sat;
        if (sat)
        begin
            res.weight_next = sum[WW] ? W_MIN : W_MAX;
        end
        else
        begin
            res.weight_next = sum[WW-1:0];
        end

        upd.step = step_sel;
        if (flip)
        begin
            res.branch_taken = rprop_pkg::BR_FLIP;
            upd.grad         = '0;
            upd.change       = flip_change;
        end
        else
        begin
            res.branch_taken = grow ? rprop_pkg::BR_GROW : rprop_pkg::BR_KEEP;
            upd.grad         = gradient;
            upd.change       = addend[WW-1:0];
        end
    end

endmodule

// ===== rtl/rprop_weight_update.sv =====
// rprop weight update: one weight per transaction, through stage 1, stage 2 and the result
// register; one transaction per cycle while result.ready holds and no clearing pass runs;
// the per-weight table read and write-back with a one-entry bypass sets the loop
// reset: registers return to floor 1 and ceiling 50.0, then a clearing pass writes
// the reset entry into every table row; item.ready is low during that pass,
// configuration writes are taken as ever
`include "rprop_weight_update_macros.svh"

module rprop_weight_update #(
    parameter int NUM_WEIGHTS = 4096
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [rprop_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [rprop_pkg::APB_DATA_W-1:0] pwdata,
    output logic [rprop_pkg::APB_DATA_W-1:0] prdata,
    output logic                             pready,
    rprop_in_if.sink                         item,
    rprop_out_if.source                      result
);

    localparam int IDX_W = (NUM_WEIGHTS > 1) ? $clog2(NUM_WEIGHTS) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_WEIGHTS - 1);
    localparam int SW = rprop_pkg::STEP_W;

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [SW-1:0] step_floor_reg;
    logic [SW-1:0] step_ceiling_reg;
    logic          cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_floor_reg   <= rprop_pkg::RESET_STEP_FLOOR;
            step_ceiling_reg <= rprop_pkg::RESET_STEP_CEILING;
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                rprop_pkg::REG_STEP_FLOOR:   step_floor_reg   <= pwdata[SW-1:0];
                rprop_pkg::REG_STEP_CEILING: step_ceiling_reg <= pwdata[SW-1:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            rprop_pkg::REG_STEP_FLOOR:   prdata = {1'b0, step_floor_reg};
            rprop_pkg::REG_STEP_CEILING: prdata = {1'b0, step_ceiling_reg};
        endcase
    end

    // ------------------------------------------------------------------
    // clearing pass after reset
    // ------------------------------------------------------------------
    logic             clr_active_reg;
    logic [IDX_W-1:0] clr_idx_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_idx_reg    <= '0;
        end
        else if (clr_active_reg)
        begin
            clr_idx_reg <= clr_idx_reg + 1'b1;
            if (clr_idx_reg == LAST_IDX)
            begin
                clr_active_reg <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // pipeline control: s1 index reduce, s2 table data + update, result reg
    // ------------------------------------------------------------------
    logic s1_valid_reg, s1_valid_next;
    logic s2_valid_reg, s2_valid_next;
    logic out_valid_reg, out_valid_next;
    logic res_load, s2_fire, s2_free, s1_fire, s1_free, item_fire;

    assign res_load   = !out_valid_reg || result.ready;
    assign s2_fire    = s2_valid_reg && res_load;
    assign s2_free    = !s2_valid_reg || res_load;
    assign s1_fire    = s1_valid_reg && s2_free;
    assign s1_free    = !s1_valid_reg || s2_free;
    assign item.ready = s1_free && !clr_active_reg;
    assign item_fire  = item.valid && item.ready;

    assign s1_valid_next  = item_fire || (s1_valid_reg && !s2_free);
    assign s2_valid_next  = s1_fire || (s2_valid_reg && !res_load);
    assign out_valid_next = s2_fire || (out_valid_reg && !result.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // ------------------------------------------------------------------
    // stage 1: input capture and index modulo table depth
    // ------------------------------------------------------------------
    logic signed [rprop_pkg::GRAD_W-1:0]   s1_grad_reg;
    logic signed [rprop_pkg::WEIGHT_W-1:0] s1_wnow_reg;
    logic [IDX_W-1:0]                      s1_idx;

    always_ff @(posedge clk)
    begin
        if (item_fire)
        begin
            s1_grad_reg <= item.gradient;
            s1_wnow_reg <= item.weight_now;
        end
    end

    rprop_idx #(
        .NUM_WEIGHTS (NUM_WEIGHTS)
    ) u_idx (
        .clk          (clk),
        .en           (item_fire),
        .weight_index (item.weight_index),
        .idx          (s1_idx)
    );

    // ------------------------------------------------------------------
    // per-weight table, one write and one registered read per cycle
    // ------------------------------------------------------------------
    rprop_pkg::entry_t ram_rdata;
    rprop_pkg::entry_t calc_upd;
    rprop_pkg::entry_t ram_wdata;
    logic [IDX_W-1:0]  ram_waddr;
    logic              ram_we;
    logic [IDX_W-1:0]  s2_idx_reg;

    assign ram_we    = clr_active_reg || s2_fire;
    assign ram_waddr = clr_active_reg ? clr_idx_reg : s2_idx_reg;
    assign ram_wdata = clr_active_reg ? rprop_pkg::ENTRY_RESET : calc_upd;

    rprop_ram #(
        .WIDTH (rprop_pkg::ENTRY_W),
        .DEPTH (NUM_WEIGHTS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (s1_fire),
        .raddr (s1_idx),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // stage 2: bypass of the write made at the read edge, then update
    // ------------------------------------------------------------------
    logic signed [rprop_pkg::GRAD_W-1:0]   s2_grad_reg;
    logic signed [rprop_pkg::WEIGHT_W-1:0] s2_wnow_reg;
    logic                                  byp_valid_reg;
    rprop_pkg::entry_t                     byp_entry_reg;
    rprop_pkg::entry_t                     prev_entry;
    rprop_pkg::result_t                    calc_res;

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            s2_idx_reg    <= s1_idx;
            s2_grad_reg   <= s1_grad_reg;
            s2_wnow_reg   <= s1_wnow_reg;
            byp_entry_reg <= calc_upd;
        end
    end

    // the table read misses a write to the same row at the same edge
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byp_valid_reg <= 1'b0;
        end
        else if (s1_fire)
        begin
            byp_valid_reg <= s2_fire && (s2_idx_reg == s1_idx);
        end
    end

    assign prev_entry = byp_valid_reg ? byp_entry_reg : ram_rdata;

    rprop_calc u_calc (
        .gradient     (s2_grad_reg),
        .weight_now   (s2_wnow_reg),
        .prev         (prev_entry),
        .step_floor   (step_floor_reg),
        .step_ceiling (step_ceiling_reg),
        .res          (calc_res),
        .upd          (calc_upd)
    );

    // ------------------------------------------------------------------
    // result register
    // ------------------------------------------------------------------
    rprop_pkg::result_t res_reg;

    always_ff @(posedge clk)
    begin
        if (s2_fire)
        begin
            res_reg <= calc_res;
        end
    end

    assign result.valid        = out_valid_reg;
    assign result.weight_next  = res_reg.weight_next;
    assign result.step_now     = res_reg.step_now;
    assign result.branch_taken = res_reg.branch_taken;
    assign result.saturated    = res_reg.saturated;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    `RPROP_ASSERT_SAME(a_clear_quiet, clr_active_reg,
        !s1_valid_reg && !s2_valid_reg && !item.ready, "transaction in flight during clear")
    `RPROP_ASSERT_SAME(a_grow_capped,
        s2_valid_reg && (calc_res.branch_taken == rprop_pkg::BR_GROW),
        calc_res.step_now <= step_ceiling_reg, "grown step above ceiling")
    `RPROP_ASSERT_SAME(a_flip_floored,
        s2_valid_reg && (calc_res.branch_taken == rprop_pkg::BR_FLIP),
        calc_res.step_now >= step_floor_reg, "shrunk step below floor")
    `RPROP_ASSERT_NEXT(a_s2_holds, s2_valid_reg && !res_load,
        s2_valid_reg && $stable(s2_idx_reg), "stage 2 lost its item while stalled")

endmodule

// ===== bench/rprop_weight_update_tb.sv =====
module rprop_weight_update_tb;

    localparam int NUM_WEIGHTS = 4096;
    localparam int LATENCY = 2;
    localparam longint Q_MAX = 64'sd2147483647;
    localparam longint Q_MIN = -64'sd2147483648;

    // one weight update request, with an optional hand-typed result
    typedef struct {
        logic [rprop_pkg::INDEX_W-1:0]         idx;
        logic signed [rprop_pkg::GRAD_W-1:0]   grad;
        logic signed [rprop_pkg::WEIGHT_W-1:0] wnow;
        bit                                    known;
        rprop_pkg::result_t                    typed;
    } update_row_t;

    logic                             clk;
    logic                             rst_n;
    logic                             psel;
    logic                             penable;
    logic                             pwrite;
    logic [rprop_pkg::APB_ADDR_W-1:0] paddr;
    logic [rprop_pkg::APB_DATA_W-1:0] pwdata;
    logic [rprop_pkg::APB_DATA_W-1:0] prdata;
    logic                             pready;

    rprop_in_if  item_ch ();
    rprop_out_if result_ch ();

    rprop_weight_update #(
        .NUM_WEIGHTS (NUM_WEIGHTS)
    ) u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .item    (item_ch),
        .result  (result_ch)
    );

    // shadow copy of the per-weight table and the two step bounds
    rprop_pkg::entry_t            weight_table [NUM_WEIGHTS];
    logic [rprop_pkg::STEP_W-1:0] floor_q;
    logic [rprop_pkg::STEP_W-1:0] ceiling_q;

    // updates still owed by the block, oldest first
    rprop_pkg::result_t expected_updates [$];
    update_row_t        directed_rows [$];
    rprop_pkg::result_t want;
    rprop_pkg::result_t seen;
    int                 fail_count;
    // when set, neither side inserts idle cycles
    bit                 no_idle;

    // clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // run limit, far above the slowest legal run
    initial
    begin
        #3_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic int unsigned idle_draw();
        if (no_idle)
            return 0;
        return $urandom_range(0, 6);
    endfunction

    function automatic int sign_q(input logic signed [31:0] v);
        return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
    endfunction

    function automatic logic signed [31:0] clip_q(input longint v, output logic hit);
        hit = 1'b1;
        if (v > Q_MAX)
            return 32'sh7FFF_FFFF;
        if (v < Q_MIN)
            return 32'sh8000_0000;
        hit = 1'b0;
        return v[31:0];
    endfunction

    // rprop+ update of one table entry, returns the result the block must produce
    function automatic rprop_pkg::result_t apply_rprop(
        input logic [rprop_pkg::INDEX_W-1:0] idx,
        input logic signed [31:0]            grad,
        input logic signed [31:0]            wnow);
        rprop_pkg::entry_t            e;
        rprop_pkg::result_t           r;
        int                           sg;
        int                           prod;
        logic [63:0]                  grown;
        logic [rprop_pkg::STEP_W-1:0] st;
        longint                       wsum;
        longint                       chg;
        logic                         hit;
        logic                         unused_hit;
        e    = weight_table[idx % NUM_WEIGHTS];
        sg   = sign_q(grad);
        prod = sg * sign_q(e.grad);
        st   = e.step;
        if (prod < 0)
        begin
            // sign flip: halve the step, undo the last change, forget the gradient
            st = e.step >> 1;
            if (st < floor_q)
                st = floor_q;
            wsum     = longint'(wnow) - longint'(e.change);
            chg      = -longint'(e.change);
            e.change = clip_q(chg, unused_hit);
            e.grad   = '0;
            r.branch_taken = rprop_pkg::BR_FLIP;
        end
        else
        begin
            if (prod > 0)
            begin
                // same sign: grow by 6/5, capped
                grown = (64'(e.step) * 64'd6) / 64'd5;
                if (grown > 64'(ceiling_q))
                    grown = 64'(ceiling_q);
                st = grown[rprop_pkg::STEP_W-1:0];
                r.branch_taken = rprop_pkg::BR_GROW;
            end
            else
            begin
                r.branch_taken = rprop_pkg::BR_KEEP;
            end
            chg      = -longint'(sg) * longint'({33'b0, st});
            wsum     = longint'(wnow) + chg;
            e.change = chg[31:0];
            e.grad   = grad;
        end
        e.step = st;
        weight_table[idx % NUM_WEIGHTS] = e;
        r.weight_next = clip_q(wsum, hit);
        r.saturated   = hit;
        r.step_now    = st;
        return r;
    endfunction

    // one apb write: setup cycle, then access cycle
    task automatic program_step_reg(input rprop_pkg::reg_sel_t sel,
                                    input logic [rprop_pkg::STEP_W-1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        // top bit is don't-care, drive it at random anyway
        pwdata  <= {1'($urandom_range(0, 1)), value};
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (sel == rprop_pkg::REG_STEP_FLOOR)
            floor_q = value;
        else
            ceiling_q = value;
    endtask

    // send one input transaction, record the expected result at acceptance
    task automatic drive_update(input update_row_t row);
        int unsigned        gap;
        rprop_pkg::result_t predicted;
        gap = idle_draw();
        if (gap != 0)
        begin
            item_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_ch.valid        <= 1'b1;
        item_ch.weight_index <= row.idx;
        item_ch.gradient     <= row.grad;
        item_ch.weight_now   <= row.wnow;
        do
            @(posedge clk);
        while (!item_ch.ready);
        predicted = apply_rprop(row.idx, row.grad, row.wnow);
        expected_updates.insert(expected_updates.size(), row.known ? row.typed : predicted);
    endtask

    // stop sending and let every owed result come back
    task automatic wait_for_results();
        item_ch.valid <= 1'b0;
        while (expected_updates.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 2) @(posedge clk);
    endtask

    task automatic add_row(input logic [rprop_pkg::INDEX_W-1:0] idx,
                           input logic signed [31:0] grad,
                           input logic signed [31:0] wnow, input bit known,
                           input logic signed [31:0] wnext,
                           input logic [rprop_pkg::STEP_W-1:0] step,
                           input rprop_pkg::branch_t br, input logic sat);
        update_row_t row;
        row.idx   = idx;
        row.grad  = grad;
        row.wnow  = wnow;
        row.known = known;
        row.typed = '{weight_next: wnext, step_now: step, branch_taken: br, saturated: sat};
        directed_rows.insert(directed_rows.size(), row);
    endtask

    // one configuration setting followed by random traffic
    // most items hammer a few hot weights so steps can reach the bounds
    task automatic run_phase(input logic [rprop_pkg::STEP_W-1:0] floor_val,
                             input logic [rprop_pkg::STEP_W-1:0] ceil_val,
                             input int hot, input int count);
        update_row_t row;
        bit          dir_neg [8];
        int          base;
        int          slot;
        logic [31:0] mag;
        wait_for_results();
        program_step_reg(rprop_pkg::REG_STEP_FLOOR, floor_val);
        program_step_reg(rprop_pkg::REG_STEP_CEILING, ceil_val);
        base = $urandom_range(0, NUM_WEIGHTS - 8);
        foreach (dir_neg[k])
            dir_neg[k] = $urandom_range(0, 1);
        for (int n = 0; n < count; n++)
        begin
            // bursts with no idling now and then
            if (n % 50 == 0)
                no_idle = ($urandom_range(0, 3) == 0);
            // hold off the sender until the pipe is empty, mid-phase
            if (n == count / 2)
                wait_for_results();
            row.known = 1'b0;
            row.typed = '0;
            if ($urandom_range(0, 9) == 0)
            begin
                // noise over the whole index and value range
                row.idx  = rprop_pkg::INDEX_W'($urandom);
                row.grad = $urandom;
                row.wnow = $urandom;
            end
            else
            begin
                slot    = $urandom_range(0, hot - 1);
                row.idx = rprop_pkg::INDEX_W'(base + slot);
                // mostly keep the sign so the step grows, sometimes flip
                if ($urandom_range(0, 7) == 0)
                    dir_neg[slot] = ~dir_neg[slot];
                case ($urandom_range(0, 3))
                    0:       mag = $urandom_range(1, 32'h0000_FFFF);
                    1:       mag = $urandom_range(1, 32'h7FFF_FFFF);
                    2:       mag = 32'd1;
                    default: mag = 32'h7FFF_FFFF;
                endcase
                if ($urandom_range(0, 15) == 0)
                    row.grad = '0;
                else if (!dir_neg[slot])
                    row.grad = mag;
                else if (mag == 32'h7FFF_FFFF && $urandom_range(0, 1) == 1)
                    row.grad = 32'sh8000_0000;
                else
                    row.grad = -mag;
                // weights often near the rails to provoke saturation
                case ($urandom_range(0, 3))
                    0:       row.wnow = 32'h7FFF_FFFF - $urandom_range(0, 32'h0000_FFFF);
                    1:       row.wnow = 32'h8000_0000 + $urandom_range(0, 32'h0000_FFFF);
                    2:       row.wnow = 32'($urandom_range(0, 131071)) - 32'd65536;
                    default: row.wnow = $urandom;
                endcase
            end
            drive_update(row);
        end
    endtask

    // result side: random stall before each transaction
    initial
    begin
        int unsigned hold;
        result_ch.ready = 1'b0;
        hold = idle_draw();
        forever
        begin
            @(posedge clk);
            if (result_ch.valid && result_ch.ready)
                hold = idle_draw();
            else if (hold != 0)
                hold--;
            result_ch.ready <= (hold == 0);
        end
    end

    // compare every result transaction against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            seen = '{weight_next:  result_ch.weight_next,
                     step_now:     result_ch.step_now,
                     branch_taken: result_ch.branch_taken,
                     saturated:    result_ch.saturated};
            if (expected_updates.size() == 0)
            begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected result: weight=%0d step=%0d branch=%0d sat=%0b",
                             seen.weight_next, seen.step_now, seen.branch_taken,
                             seen.saturated);
            end
            else
            begin
                want = expected_updates.pop_front();
                if (seen !== want)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("mismatch: exp w=%0d s=%0d b=%0d sat=%0b got w=%0d s=%0d b=%0d sat=%0b",
                                 want.weight_next, want.step_now, want.branch_taken,
                                 want.saturated, seen.weight_next, seen.step_now,
                                 seen.branch_taken, seen.saturated);
                end
            end
        end
    end

    // main sequence
    initial
    begin
        rst_n                = 1'b0;
        psel                 = 1'b0;
        penable              = 1'b0;
        pwrite               = 1'b0;
        paddr                = '0;
        pwdata               = '0;
        item_ch.valid        = 1'b0;
        item_ch.weight_index = '0;
        item_ch.gradient     = '0;
        item_ch.weight_now   = '0;
        fail_count           = 0;
        no_idle              = 1'b0;
        floor_q              = rprop_pkg::RESET_STEP_FLOOR;
        ceiling_q            = rprop_pkg::RESET_STEP_CEILING;
        foreach (weight_table[k])
            weight_table[k] = rprop_pkg::ENTRY_RESET;

        // directed rows, all with the reset bounds
        // grow from the reset entry
        add_row(12'd0, 32'sd1, 32'sd0, 1, -32'sd7864, 31'd7864, rprop_pkg::BR_GROW, 1'b0);
        // sign flip undoes the last change
        add_row(12'd0, -32'sd1, 32'sd100, 1, 32'sd7964, 31'd3932, rprop_pkg::BR_FLIP, 1'b0);
        // stored gradient is zero after a flip
        add_row(12'd0, 32'sd5, 32'sd0, 1, -32'sd3932, 31'd3932, rprop_pkg::BR_KEEP, 1'b0);
        // zero gradient passes the weight through
        add_row(12'd1, 32'sd0, 32'sh7FFF_FFFF, 1, 32'sh7FFF_FFFF, 31'd6554,
                rprop_pkg::BR_KEEP, 1'b0);
        // most negative gradient
        add_row(12'd2, 32'sh8000_0000, 32'sh7FFF_FFFF, 1, 32'sd2147477093, 31'd3277,
                rprop_pkg::BR_FLIP, 1'b0);
        // last table entry, clip at the bottom
        add_row(12'd4095, 32'sh7FFF_FFFF, 32'sh8000_0000, 1, 32'sh8000_0000, 31'd7864,
                rprop_pkg::BR_GROW, 1'b1);
        // backtrack clips at the bottom
        add_row(12'd4, -32'sd1, 32'sh8000_0000, 1, 32'sh8000_0000, 31'd3277,
                rprop_pkg::BR_FLIP, 1'b1);
        // keep after flip clips at the top
        add_row(12'd4, -32'sd5, 32'sh7FFF_FFF0, 1, 32'sh7FFF_FFFF, 31'd3277,
                rprop_pkg::BR_KEEP, 1'b1);
        add_row(12'd4, -32'sd5, 32'sd0, 1, 32'sd3932, 31'd3932, rprop_pkg::BR_GROW, 1'b0);
        add_row(12'd5, 32'sh0001_0000, 32'sh1234_5678, 1, 32'sd305412032, 31'd7864,
                rprop_pkg::BR_GROW, 1'b0);
        add_row(12'd3, 32'sd0, 32'sh8000_0000, 1, 32'sh8000_0000, 31'd6554,
                rprop_pkg::BR_KEEP, 1'b0);
        add_row(12'd3, 32'sd1, 32'sd0, 1, -32'sd6554, 31'd6554, rprop_pkg::BR_KEEP, 1'b0);
        add_row(12'd3, 32'sd1, 32'sd0, 1, -32'sd7864, 31'd7864, rprop_pkg::BR_GROW, 1'b0);
        // from here on the shadow table decides
        add_row(12'd3, -32'sh7FFF_FFFF, 32'sd0, 0, '0, '0, rprop_pkg::BR_GROW, 1'b0);
        add_row(12'd3, 32'sh0001_0000, 32'sd0, 0, '0, '0, rprop_pkg::BR_GROW, 1'b0);
        add_row(12'hAAA, 32'sh5555_5555, 32'shAAAA_AAAA, 0, '0, '0, rprop_pkg::BR_GROW, 1'b0);
        add_row(12'h555, 32'shAAAA_AAAA, 32'sh5555_5555, 0, '0, '0, rprop_pkg::BR_GROW, 1'b0);
        add_row(12'd4095, -32'sd1, 32'sd0, 0, '0, '0, rprop_pkg::BR_GROW, 1'b0);
        add_row(12'd4095, -32'sd1, 32'sh7FFF_FFFF, 0, '0, '0, rprop_pkg::BR_GROW, 1'b0);
        // same weight back to back exercises the bypass
        add_row(12'd6, 32'sd1, 32'sd0, 0, '0, '0, rprop_pkg::BR_GROW, 1'b0);
        add_row(12'd6, 32'sd1, 32'sd0, 0, '0, '0, rprop_pkg::BR_GROW, 1'b0);
        add_row(12'd6, -32'sd1, 32'sd0, 0, '0, '0, rprop_pkg::BR_GROW, 1'b0);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // ready stays low through the table clear after reset
        foreach (directed_rows[k])
            drive_update(directed_rows[k]);

        // bound settings: reset values, widest, floor above ceiling, zero, narrow, floor above ceiling again
        run_phase(31'd1, 31'd3276800, 8, 250);
        run_phase(31'd0, 31'h7FFF_FFFF, 2, 300);
        run_phase(31'h7FFF_FFFF, 31'd0, 8, 250);
        run_phase(31'd0, 31'd0, 4, 250);
        run_phase(31'd20000, 31'd100000, 6, 300);
        run_phase(31'd500000, 31'd300000, 4, 300);

        wait_for_results();
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
